@@ src/chp_pkg.sv @@
// shared constants and control types for the convex hull perimeter block
package chp_pkg;

	localparam int MAX_POINTS_D   = 64;
	localparam int COORD_BITS_D   = 16;
	localparam int FRAC_BITS_D    = 8;
	localparam int RESULT_LIMIT   = 64;
	localparam int PERIM_W        = 31;
	localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
	localparam int SQ_IN_W        = 62;
	localparam int SQ_ROOT_W      = 31;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic run_done;
		logic s_init;
		logic s_getv;
		logic s_mv;
		logic s_dec;
		logic s_put;
		logic s_put0;
		logic s_next;
		logic h_init;
		logic h_getp;
		logic h_pop;
		logic h_popa;
		logic h_push;
		logic diff;
		logic edge_mode;
		logic mul1;
		logic mul2;
		logic e_sum;
		logic sq_start;
		logic e_acc;
		logic p_init;
		logic p_first;
		logic p_next;
		logic o_init;
		logic o_ld;
		logic o_empty;
		logic o_adv;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_le1;
		logic s_last;
		logic less;
		logic j_zero;
		logic k_ge_lim;
		logic cross_le0;
		logic hull_end;
		logic empty;
		logic p_last;
		logic sq_done;
		logic out_last;
	} sts_t;

endpackage

@@ src/convex_hull_perimeter.sv @@
// top level: convex hull (monotone chain) of a point set with closed perimeter
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    x_coord, y_coord, last_point
// out      out  out_valid / out_ready  vertex_x, vertex_y, vertex_valid, last_vertex,
//                                      perimeter_q8, overflow
//
// points load at one item per cycle while in_ready is high; an item with last_point
// starts the run and in_ready stays low until the final result is taken
// insertion sort on the point memory, which has one write port and one read port
// hull build: point fetch, cross product and pop each run as a sequence of controller states
// perimeter: each edge length comes from the 31-step square root unit
// output: each result is loaded into the result register, which holds its payload
// while out_ready is low
// reset clears the controller and counters; memories need no clearing pass
module convex_hull_perimeter #(
	parameter int MAX_POINTS = chp_pkg::MAX_POINTS_D,
	parameter int COORD_BITS = chp_pkg::COORD_BITS_D,
	parameter int FRAC_BITS  = chp_pkg::FRAC_BITS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         last_point,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] vertex_x,
	output logic signed [COORD_BITS-1:0] vertex_y,
	output logic                         vertex_valid,
	output logic                         last_vertex,
	output logic [chp_pkg::PERIM_W-1:0]  perimeter_q8,
	output logic                         overflow
);
	chp_pkg::cmd_t cmd;
	chp_pkg::sts_t sts;

	// sequencer
	chp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (last_point),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// memories, arithmetic and result register
	chp_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_valid (vertex_valid),
		.last_vertex  (last_vertex),
		.perimeter_q8 (perimeter_q8),
		.overflow     (overflow)
	);

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("load and output active together");

	// taking the final item returns the block to loading
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_vertex |=> in_ready)
		else $error("not back to load after final item");

	// an empty hull is always the final item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !vertex_valid |-> last_vertex)
		else $error("empty hull item not final");

	// perimeter only on the final item
	a_perim_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_vertex |-> perimeter_q8 == '0)
		else $error("perimeter on a non-final item");

endmodule

@@ src/chp_sqrt.sv @@
// iterative rounded integer square root, one result bit per cycle
module chp_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [chp_pkg::SQ_IN_W-1:0]     radicand,
	output logic                            done,
	output logic [chp_pkg::SQ_ROOT_W:0]     root
);
	localparam int RW = chp_pkg::SQ_ROOT_W;
	localparam int IW = chp_pkg::SQ_IN_W;
	localparam int CW = $clog2(RW + 1);

	logic [IW-1:0] rad_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [RW:0]   res_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [RW+3:0] rem_sh;
	logic [RW+3:0] trial;
	logic [RW+3:0] rem_sub;
	logic          ge;

	always_comb begin
		rem_sh  = {rem_q, rad_q[IW-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		ge      = rem_sh >= trial;
		rem_sub = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(RW)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(RW)) begin
				// round to nearest: remainder above the root rounds up
				res_q <= {1'b0, root_q} + (RW+1)'(rem_q > {2'b00, root_q});
			end else begin
				rad_q  <= {rad_q[IW-3:0], 2'b00};
				rem_q  <= rem_sub[RW+1:0];
				root_q <= {root_q[RW-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign root = res_q;

endmodule

@@ src/chp_dp.sv @@
// datapath: point and hull memories, sort, cross product, edge length, output registers
module chp_dp #(
	parameter int MAX_POINTS = chp_pkg::MAX_POINTS_D,
	parameter int COORD_BITS = chp_pkg::COORD_BITS_D,
	parameter int FRAC_BITS  = chp_pkg::FRAC_BITS_D
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chp_pkg::cmd_t               cmd,
	output chp_pkg::sts_t               sts,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	output logic signed [COORD_BITS-1:0] vertex_x,
	output logic signed [COORD_BITS-1:0] vertex_y,
	output logic                        vertex_valid,
	output logic                        last_vertex,
	output logic [chp_pkg::PERIM_W-1:0] perimeter_q8,
	output logic                        overflow
);
	localparam int C  = COORD_BITS;
	localparam int PW = 2 * C;
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int PA = $clog2(MAX_POINTS);
	localparam int HD = 2 * MAX_POINTS;
	localparam int KW = $clog2(HD + 1);
	localparam int HA = $clog2(HD);
	localparam int DW = 2 * C + 2;
	localparam int QW = chp_pkg::PERIM_W;
	localparam logic [63:0] SAT_THR = 64'd1 << (chp_pkg::SQ_IN_W - 2 * FRAC_BITS);

	function automatic logic signed [C:0] px(input logic [PW-1:0] p);
		px = {p[C-1], p[C-1:0]};
	endfunction

	function automatic logic signed [C:0] py(input logic [PW-1:0] p);
		py = {p[PW-1], p[PW-1:C]};
	endfunction

	// memories
	logic [PW-1:0] pmem [MAX_POINTS];
	logic [PW-1:0] hmem [HD];
	logic [PA-1:0] p_ra_q;
	logic [HA-1:0] h_ra_q;
	logic [PW-1:0] p_rd_q;
	logic [PW-1:0] h_rd_q;

	logic          p_we;
	logic [PA-1:0] p_wa;
	logic [PW-1:0] p_wd;

	// control state
	logic [NW-1:0] n_q;
	logic          drop_q;
	logic [NW-1:0] i_q;
	logic [NW-1:0] j_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] t_q;
	logic          upper_q;
	logic [KW-1:0] pi_q;
	logic [KW-1:0] oi_q;

	// payload
	logic [PW-1:0] v_q, p_q, a_q, b_q, first_q;
	logic signed [C:0]    e0_q, e1_q, e2_q, e3_q;
	logic signed [DW-1:0] m1_q, m2_q;
	logic [DW-1:0]        d2_q;
	logic                 sat_q;
	logic [QW-1:0]        sum_q;

	// helpers
	logic [NW-1:0] i_inc, i_dec, j_inc, j_dec, n_dec, n_dec2;
	logic [KW-1:0] k_inc, k_dec3, h_w, pi_inc, pi_inc2, oi_inc;
	logic signed [C:0]    dbx, dby, dpx, dpy;
	logic signed [DW-1:0] prod;
	logic [63:0]          d2_wide;
	logic [63:0]          d2_sh;
	logic                 sq_done;
	logic [QW:0]          sq_root;
	logic [QW-1:0]        len;
	logic [QW:0]          sum_n;
	logic                 o_last;

	always_comb begin
		i_inc   = i_q + 1'b1;
		i_dec   = i_q - 1'b1;
		j_inc   = j_q + 1'b1;
		j_dec   = j_q - 1'b1;
		n_dec   = n_q - 1'b1;
		n_dec2  = n_q - NW'(2);
		k_inc   = k_q + 1'b1;
		k_dec3  = k_q - KW'(3);
		h_w     = k_q - 1'b1;
		pi_inc  = pi_q + 1'b1;
		pi_inc2 = pi_q + KW'(2);
		oi_inc  = oi_q + 1'b1;

		dbx = px(b_q) - px(a_q);
		dby = py(b_q) - py(a_q);
		dpx = px(p_q) - px(a_q);
		dpy = py(p_q) - py(a_q);

		// one shared multiplier for both products
		prod = cmd.mul2 ? DW'(e2_q * e3_q) : DW'(e0_q * e1_q);

		d2_wide = 64'(d2_q);
		d2_sh   = d2_wide << (2 * FRAC_BITS);

		if (sat_q || sq_root > {1'b0, chp_pkg::PERIM_MAX}) begin
			len = chp_pkg::PERIM_MAX;
		end else begin
			len = sq_root[QW-1:0];
		end
		sum_n = {1'b0, sum_q} + {1'b0, len};

		o_last = (oi_inc == h_w) || (int'(oi_q) + 1 == chp_pkg::RESULT_LIMIT);
	end

	// status
	always_comb begin
		sts.n_le1     = n_q <= NW'(1);
		sts.s_last    = i_q == n_dec;
		sts.less      = (px(v_q) < px(p_rd_q)) ||
		                (px(v_q) == px(p_rd_q) && py(v_q) < py(p_rd_q));
		sts.j_zero    = j_q == '0;
		sts.k_ge_lim  = upper_q ? (k_q >= t_q) : (k_q >= KW'(2));
		sts.cross_le0 = m1_q <= m2_q;
		sts.hull_end  = upper_q ? (i_q == '0) : (i_q == n_dec && n_q == NW'(1));
		sts.empty     = k_q <= KW'(1);
		sts.p_last    = pi_inc == h_w;
		sts.sq_done   = sq_done;
		sts.out_last  = last_vertex;
	end

	// point memory write port
	always_comb begin
		p_we = 1'b0;
		p_wa = '0;
		p_wd = v_q;
		if (cmd.load) begin
			p_we = n_q < NW'(MAX_POINTS);
			p_wa = n_q[PA-1:0];
			p_wd = {y_coord, x_coord};
		end else if (cmd.s_mv) begin
			p_we = 1'b1;
			p_wa = j_inc[PA-1:0];
			p_wd = p_rd_q;
		end else if (cmd.s_put) begin
			p_we = 1'b1;
			p_wa = j_inc[PA-1:0];
		end else if (cmd.s_put0) begin
			p_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[p_wa] <= p_wd;
		end
		p_rd_q <= pmem[p_ra_q];
		if (cmd.h_push) begin
			hmem[k_q[HA-1:0]] <= p_q;
		end
		h_rd_q <= hmem[h_ra_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			t_q     <= '0;
			upper_q <= 1'b0;
			pi_q    <= '0;
			oi_q    <= '0;
			p_ra_q  <= '0;
			h_ra_q  <= '0;
		end else begin
			if (cmd.load) begin
				if (n_q < NW'(MAX_POINTS)) begin
					n_q <= n_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.run_done) begin
				n_q    <= '0;
				drop_q <= 1'b0;
			end
			if (cmd.s_init) begin
				i_q    <= NW'(1);
				p_ra_q <= PA'(1);
			end
			if (cmd.s_getv) begin
				j_q    <= i_dec;
				p_ra_q <= i_dec[PA-1:0];
			end
			if (cmd.s_dec) begin
				j_q    <= j_dec;
				p_ra_q <= j_dec[PA-1:0];
			end
			if (cmd.s_next) begin
				i_q    <= i_inc;
				p_ra_q <= i_inc[PA-1:0];
			end
			if (cmd.h_init) begin
				i_q     <= '0;
				k_q     <= '0;
				upper_q <= 1'b0;
				p_ra_q  <= '0;
			end
			if (cmd.h_pop) begin
				k_q    <= k_q - 1'b1;
				h_ra_q <= k_dec3[HA-1:0];
			end
			if (cmd.h_push) begin
				k_q <= k_inc;
				if (!upper_q) begin
					if (i_q == n_dec) begin
						upper_q <= 1'b1;
						t_q     <= k_q + KW'(2);
						i_q     <= n_dec2;
						p_ra_q  <= n_dec2[PA-1:0];
					end else begin
						i_q    <= i_inc;
						p_ra_q <= i_inc[PA-1:0];
					end
				end else begin
					i_q    <= i_dec;
					p_ra_q <= i_dec[PA-1:0];
				end
			end
			if (cmd.p_init) begin
				pi_q   <= '0;
				h_ra_q <= '0;
			end
			if (cmd.p_first) begin
				h_ra_q <= HA'(1);
			end
			if (cmd.e_acc) begin
				pi_q   <= pi_inc;
				h_ra_q <= pi_inc2[HA-1:0];
			end
			if (cmd.o_init) begin
				oi_q   <= '0;
				h_ra_q <= '0;
			end
			if (cmd.o_adv) begin
				oi_q   <= oi_inc;
				h_ra_q <= oi_inc[HA-1:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.s_getv) begin
			v_q <= p_rd_q;
		end
		if (cmd.h_getp) begin
			p_q <= p_rd_q;
		end
		if (cmd.h_pop) begin
			b_q <= a_q;
		end
		if (cmd.h_popa) begin
			a_q <= h_rd_q;
		end
		if (cmd.h_push) begin
			a_q <= b_q;
			b_q <= p_q;
		end
		if (cmd.diff) begin
			e0_q <= dbx;
			e2_q <= dby;
			e1_q <= cmd.edge_mode ? dbx : dpy;
			e3_q <= cmd.edge_mode ? dby : dpx;
		end
		if (cmd.mul1) begin
			m1_q <= prod;
		end
		if (cmd.mul2) begin
			m2_q <= prod;
		end
		if (cmd.e_sum) begin
			d2_q <= $unsigned(m1_q) + $unsigned(m2_q);
		end
		if (cmd.sq_start) begin
			sat_q <= d2_wide >= SAT_THR;
		end
		if (cmd.p_init) begin
			sum_q <= '0;
		end
		if (cmd.p_first) begin
			first_q <= h_rd_q;
			a_q     <= h_rd_q;
		end
		if (cmd.p_next) begin
			b_q <= sts.p_last ? first_q : h_rd_q;
		end
		if (cmd.e_acc) begin
			sum_q <= sum_n[QW] ? chp_pkg::PERIM_MAX : sum_n[QW-1:0];
			a_q   <= b_q;
		end
		if (cmd.o_ld) begin
			vertex_x     <= h_rd_q[C-1:0];
			vertex_y     <= h_rd_q[PW-1:C];
			vertex_valid <= 1'b1;
			last_vertex  <= o_last;
			perimeter_q8 <= o_last ? sum_q : '0;
			overflow     <= drop_q;
		end
		if (cmd.o_empty) begin
			vertex_x     <= '0;
			vertex_y     <= '0;
			vertex_valid <= 1'b0;
			last_vertex  <= 1'b1;
			perimeter_q8 <= '0;
			overflow     <= drop_q;
		end
	end

	chp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (d2_sh[chp_pkg::SQ_IN_W-1:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

endmodule

@@ src/chp_ctrl.sv @@
// controller: state machine sequencing load, sort, hull, perimeter and output
module chp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_point,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  chp_pkg::sts_t sts,
	output chp_pkg::cmd_t cmd
);
	localparam int SW = 37;

	typedef enum logic [SW-1:0] {
		ST_LOAD    = SW'(1) << 0,
		ST_S_INIT  = SW'(1) << 1,
		ST_S_W1    = SW'(1) << 2,
		ST_S_GETV  = SW'(1) << 3,
		ST_S_W2    = SW'(1) << 4,
		ST_S_CMP   = SW'(1) << 5,
		ST_S_INS0  = SW'(1) << 6,
		ST_S_NEXT  = SW'(1) << 7,
		ST_H_INIT  = SW'(1) << 8,
		ST_H_W     = SW'(1) << 9,
		ST_H_GETP  = SW'(1) << 10,
		ST_H_CHK   = SW'(1) << 11,
		ST_T_DIFF  = SW'(1) << 12,
		ST_T_MUL1  = SW'(1) << 13,
		ST_T_MUL2  = SW'(1) << 14,
		ST_T_CMP   = SW'(1) << 15,
		ST_H_POP   = SW'(1) << 16,
		ST_H_POPW  = SW'(1) << 17,
		ST_H_POPA  = SW'(1) << 18,
		ST_H_PUSH  = SW'(1) << 19,
		ST_P_INIT  = SW'(1) << 20,
		ST_P_W0    = SW'(1) << 21,
		ST_P_FIRST = SW'(1) << 22,
		ST_P_W1    = SW'(1) << 23,
		ST_P_NEXT  = SW'(1) << 24,
		ST_E_DIFF  = SW'(1) << 25,
		ST_E_MUL1  = SW'(1) << 26,
		ST_E_MUL2  = SW'(1) << 27,
		ST_E_SUM   = SW'(1) << 28,
		ST_E_START = SW'(1) << 29,
		ST_E_WAIT  = SW'(1) << 30,
		ST_E_ACC   = SW'(1) << 31,
		ST_O_INIT  = SW'(1) << 32,
		ST_O_W     = SW'(1) << 33,
		ST_O_LD    = SW'(1) << 34,
		ST_O_EMPTY = SW'(1) << 35,
		ST_O_WAIT  = SW'(1) << 36
	} state_t;

	state_t state_q, state_n;

	assign in_ready  = state_q == ST_LOAD;
	assign out_valid = state_q == ST_O_WAIT;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_point) begin
						state_n = ST_S_INIT;
					end
				end
			end
			ST_S_INIT: begin
				if (sts.n_le1) begin
					state_n = ST_H_INIT;
				end else begin
					cmd.s_init = 1'b1;
					state_n    = ST_S_W1;
				end
			end
			ST_S_W1: state_n = ST_S_GETV;
			ST_S_GETV: begin
				cmd.s_getv = 1'b1;
				state_n    = ST_S_W2;
			end
			ST_S_W2: state_n = ST_S_CMP;
			ST_S_CMP: begin
				if (sts.less) begin
					cmd.s_mv = 1'b1;
					if (sts.j_zero) begin
						state_n = ST_S_INS0;
					end else begin
						cmd.s_dec = 1'b1;
						state_n   = ST_S_W2;
					end
				end else begin
					cmd.s_put = 1'b1;
					state_n   = ST_S_NEXT;
				end
			end
			ST_S_INS0: begin
				cmd.s_put0 = 1'b1;
				state_n    = ST_S_NEXT;
			end
			ST_S_NEXT: begin
				if (sts.s_last) begin
					state_n = ST_H_INIT;
				end else begin
					cmd.s_next = 1'b1;
					state_n    = ST_S_W1;
				end
			end
			ST_H_INIT: begin
				cmd.h_init = 1'b1;
				state_n    = ST_H_W;
			end
			ST_H_W: state_n = ST_H_GETP;
			ST_H_GETP: begin
				cmd.h_getp = 1'b1;
				state_n    = ST_H_CHK;
			end
			ST_H_CHK: state_n = sts.k_ge_lim ? ST_T_DIFF : ST_H_PUSH;
			ST_T_DIFF: begin
				cmd.diff = 1'b1;
				state_n  = ST_T_MUL1;
			end
			ST_T_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = ST_T_MUL2;
			end
			ST_T_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = ST_T_CMP;
			end
			ST_T_CMP: state_n = sts.cross_le0 ? ST_H_POP : ST_H_PUSH;
			ST_H_POP: begin
				cmd.h_pop = 1'b1;
				state_n   = ST_H_POPW;
			end
			ST_H_POPW: state_n = ST_H_POPA;
			ST_H_POPA: begin
				cmd.h_popa = 1'b1;
				state_n    = ST_H_CHK;
			end
			ST_H_PUSH: begin
				cmd.h_push = 1'b1;
				state_n    = sts.hull_end ? ST_P_INIT : ST_H_W;
			end
			ST_P_INIT: begin
				cmd.p_init = 1'b1;
				state_n    = sts.empty ? ST_O_EMPTY : ST_P_W0;
			end
			ST_P_W0: state_n = ST_P_FIRST;
			ST_P_FIRST: begin
				cmd.p_first = 1'b1;
				state_n     = ST_P_W1;
			end
			ST_P_W1: state_n = ST_P_NEXT;
			ST_P_NEXT: begin
				cmd.p_next = 1'b1;
				state_n    = ST_E_DIFF;
			end
			ST_E_DIFF: begin
				cmd.diff      = 1'b1;
				cmd.edge_mode = 1'b1;
				state_n       = ST_E_MUL1;
			end
			ST_E_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = ST_E_MUL2;
			end
			ST_E_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = ST_E_SUM;
			end
			ST_E_SUM: begin
				cmd.e_sum = 1'b1;
				state_n   = ST_E_START;
			end
			ST_E_START: begin
				cmd.sq_start = 1'b1;
				state_n      = ST_E_WAIT;
			end
			ST_E_WAIT: begin
				if (sts.sq_done) begin
					state_n = ST_E_ACC;
				end
			end
			ST_E_ACC: begin
				cmd.e_acc = 1'b1;
				state_n   = sts.p_last ? ST_O_INIT : ST_P_W1;
			end
			ST_O_INIT: begin
				cmd.o_init = 1'b1;
				state_n    = ST_O_W;
			end
			ST_O_W: state_n = ST_O_LD;
			ST_O_LD: begin
				cmd.o_ld = 1'b1;
				state_n  = ST_O_WAIT;
			end
			ST_O_EMPTY: begin
				cmd.o_empty = 1'b1;
				state_n     = ST_O_WAIT;
			end
			ST_O_WAIT: begin
				if (out_ready) begin
					if (sts.out_last) begin
						cmd.run_done = 1'b1;
						state_n      = ST_LOAD;
					end else begin
						cmd.o_adv = 1'b1;
						state_n   = ST_O_W;
					end
				end
			end
			default: state_n = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ bench/tb_convex_hull_perimeter.sv @@
// testbench for the convex hull perimeter block: directed and random point sets checked against a hull predictor
`timescale 1ns / 1ps
module tb_convex_hull_perimeter;

	localparam int CAP = 64;
	localparam int FB  = 8;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               fin;
	} point_item_t;

	typedef struct {
		logic signed [15:0]          vx;
		logic signed [15:0]          vy;
		logic                        vv;
		logic                        lv;
		logic [chp_pkg::PERIM_W-1:0] perim;
		logic                        ovf;
	} hull_vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] x_coord = '0;
	logic signed [15:0] y_coord = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] vertex_x;
	logic signed [15:0] vertex_y;
	logic vertex_valid;
	logic last_vertex;
	logic [chp_pkg::PERIM_W-1:0] perimeter_q8;
	logic overflow;

	convex_hull_perimeter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_coord(x_coord), .y_coord(y_coord), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_valid(vertex_valid),
		.last_vertex(last_vertex), .perimeter_q8(perimeter_q8), .overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pending points for the driver, expected hull vertices for the monitor
	point_item_t  pending_points[$];
	hull_vertex_t expected_vertices[$];
	int mismatches = 0;

	// predictor copy of the set being loaded
	longint set_x[CAP];
	longint set_y[CAP];
	int     set_count = 0;
	bit     set_dropped = 1'b0;

	// stimulus controls
	bit send_hold = 1'b0;     // sender pause until drained
	int long_stall = 0;       // receiver hold-off, in cycles

	function automatic longint rounded_root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		if (v > res) res++;
		return res;
	endfunction

	function automatic longint unsigned edge_q8(longint ax, longint ay, longint bx, longint by);
		longint unsigned dx, dy, d2, len;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		d2 = dx * dx + dy * dy;
		if (d2 >= (64'd1 << (62 - 2 * FB))) return 64'h7FFF_FFFF;
		len = rounded_root(d2 << (2 * FB));
		return (len > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : len;
	endfunction

	function automatic longint cross_turn(longint ox, longint oy, longint ax, longint ay,
			longint bx, longint by);
		return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
	endfunction

	// take one accepted point; on the last point of a set, queue the hull vertices
	task automatic predict_hull(point_item_t p);
		longint hx[2*CAP];
		longint hy[2*CAP];
		longint vx, vy;
		longint unsigned sum;
		int n, i, j, k, t, h, emit;
		hull_vertex_t r;
		if (set_count < CAP) begin
			set_x[set_count] = p.x;
			set_y[set_count] = p.y;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!p.fin) return;
		n = set_count;
		// insertion sort by x then y
		for (i = 1; i < n; i++) begin
			vx = set_x[i];
			vy = set_y[i];
			j = i - 1;
			while (j >= 0 && (vx < set_x[j] || (vx == set_x[j] && vy < set_y[j]))) begin
				set_x[j+1] = set_x[j];
				set_y[j+1] = set_y[j];
				j--;
			end
			set_x[j+1] = vx;
			set_y[j+1] = vy;
		end
		k = 0;
		for (i = 0; i < n; i++) begin
			while (k >= 2 && cross_turn(hx[k-2], hy[k-2], hx[k-1], hy[k-1],
					set_x[i], set_y[i]) <= 0) k--;
			hx[k] = set_x[i]; hy[k] = set_y[i]; k++;
		end
		t = k + 1;
		for (i = n - 2; i >= 0; i--) begin
			while (k >= t && cross_turn(hx[k-2], hy[k-2], hx[k-1], hy[k-1],
					set_x[i], set_y[i]) <= 0) k--;
			hx[k] = set_x[i]; hy[k] = set_y[i]; k++;
		end
		h = k - 1;
		sum = 0;
		for (i = 0; i < h; i++) begin
			j = (i + 1 == h) ? 0 : i + 1;
			sum += edge_q8(hx[i], hy[i], hx[j], hy[j]);
			if (sum > 64'h7FFF_FFFF) sum = 64'h7FFF_FFFF;
		end
		if (h <= 0) begin
			r = '{vx: '0, vy: '0, vv: 1'b0, lv: 1'b1, perim: '0, ovf: set_dropped};
			expected_vertices.push_back(r);
		end else begin
			emit = (h > chp_pkg::RESULT_LIMIT) ? chp_pkg::RESULT_LIMIT : h;
			for (i = 0; i < emit; i++) begin
				r.vx = hx[i][15:0];
				r.vy = hy[i][15:0];
				r.vv = 1'b1;
				r.lv = (i + 1 == emit);
				r.perim = r.lv ? sum[chp_pkg::PERIM_W-1:0] : '0;
				r.ovf = set_dropped;
				expected_vertices.push_back(r);
			end
		end
		set_count = 0;
		set_dropped = 1'b0;
	endtask

	// driver: bursts with random gaps, payload held until accepted
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_hull('{x: x_coord, y: y_coord, fin: last_point});
				void'(pending_points.pop_front());
			end
			if (in_valid && !in_ready) begin
				// keep offering the same item
			end else if (pending_points.size() == 0 || send_hold) begin
				in_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				x_coord <= pending_points[0].x;
				y_coord <= pending_points[0].y;
				last_point <= pending_points[0].fin;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// the pending item for the front must be visible after acceptance: pop happens
	// before the next item is read, so index zero is always the next one

	// receiver stall pattern plus an occasional long hold-off
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			if (long_stall > 0) begin
				long_stall <= long_stall - 1;
				out_ready <= 1'b0;
			end else if (stall_phase[8]) begin
				out_ready <= 1'b1;   // stretch with no stalls
			end else begin
				out_ready <= (stall_phase % 7 < 4) ^ ($urandom_range(0, 4) == 0);
			end
		end
	end

	// monitor: compare each taken result with the oldest expectation
	always @(posedge clk) begin
		hull_vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d", vertex_x, vertex_y);
			end else begin
				e = expected_vertices.pop_front();
				if (vertex_x !== e.vx || vertex_y !== e.vy || vertex_valid !== e.vv ||
						last_vertex !== e.lv || perimeter_q8 !== e.perim ||
						overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d,%0d v%0b l%0b p%0d o%0b got %0d,%0d v%0b l%0b p%0d o%0b",
							e.vx, e.vy, e.vv, e.lv, e.perim, e.ovf, vertex_x, vertex_y,
							vertex_valid, last_vertex, perimeter_q8, overflow);
				end
			end
		end
	end

	task automatic add_point(int x, int y, bit fin);
		pending_points.push_back('{x: x[15:0], y: y[15:0], fin: fin});
	endtask

	// random set: mostly small, sometimes near or beyond capacity
	task automatic add_random_set(int n, int span);
		for (int i = 0; i < n; i++) begin
			if (span >= 32768)
				add_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
					i == n - 1);
			else
				add_point($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
					i == n - 1);
		end
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0 || in_valid || expected_vertices.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int items;
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// single point, empty hull
		add_point(5, -7, 1'b1);
		// two points at opposite extremes, longest possible edge
		add_point(-32768, -32768, 1'b0);
		add_point(32767, 32767, 1'b1);
		// duplicates
		add_point(3, 3, 1'b0);
		add_point(3, 3, 1'b1);
		// collinear points are dropped
		add_point(0, 0, 1'b0);
		add_point(2, 2, 1'b0);
		add_point(4, 4, 1'b0);
		add_point(4, 0, 1'b1);
		// square with interior point and bit-pattern extremes
		add_point(-32768, 32767, 1'b0);
		add_point(32767, -32768, 1'b0);
		add_point(-1, 0, 1'b0);
		add_point(32767, 32767, 1'b0);
		add_point(-32768, -32768, 1'b1);
		// unit triangle, fractional perimeter
		add_point(0, 0, 1'b0);
		add_point(1, 0, 1'b0);
		add_point(0, 1, 1'b1);
		items = 17;

		// sender waits until all of that has drained
		send_hold = 1'b0;
		wait_drained();
		send_hold = 1'b1;
		repeat (20) @(posedge clk);
		send_hold = 1'b0;

		// capacity exceeded, wide coordinates; receiver holds off a long while
		// once the first result shows, with the next set already offered
		add_random_set(70, 32768);
		items += 70;
		add_random_set(5, 100);
		items += 5;
		while (!out_valid) @(negedge clk);
		long_stall = 600;

		// points on a circle-ish spread give long hulls
		n = 64;
		for (int i = 0; i < n; i++) begin
			real a;
			a = 6.2831853 * i / n;
			add_point($rtoi(20000.0 * $cos(a)), $rtoi(20000.0 * $sin(a)), i == n - 1);
		end
		items += n;

		while (items < 215) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 8);
			add_random_set(n, ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(1, 50));
			items += n;
		end

		wait_drained();
		repeat (3000) @(posedge clk);
		if (mismatches == 0 && expected_vertices.size() == 0)
			$display("convex_hull_perimeter verification clean");
		else
			$display("convex_hull_perimeter verification failed");
		$finish;
	end

	initial begin
		#60ms;
		$display("convex_hull_perimeter verification failed");
		$finish;
	end

endmodule
